// ----- rtl/core/first_fit_block_allocator_defines.svh -----
// Assertion macros for the first-fit block allocator checkers.
// Used by ffba_checker; no other dependencies.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication under reset.
`define FFBA_AST_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("ffba assertion failed");

// Next-cycle implication under reset.
`define FFBA_AST_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("ffba assertion failed");

`endif

// ----- rtl/core/ffba_pkg.sv -----
// Shared types and constants of the first-fit block allocator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ffba_pkg;

	localparam int PAGE_BYTES_DEF       = 4096;
	localparam int BLOCK_HDR_BYTES_DEF  = 48;
	localparam int DEVICE_HDR_BYTES_DEF = 64;
	localparam int MAX_FREE_BLOCKS_DEF  = 16;
	localparam int MAX_ALLOCATIONS_DEF  = 16;

	localparam logic [31:0] POOL_RESET   = 32'd4194304;
	localparam logic [31:0] POOL_MIN_RAW = 32'd2097152;

	typedef enum logic [1:0] {
		KIND_RESERVE = 2'd0,
		KIND_RELEASE = 2'd1,
		KIND_READ    = 2'd2,
		KIND_WRITE   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_INVAL = 2'd1,
		ST_NOMEM = 2'd2
	} status_t;

	typedef struct packed {
		kind_t       kind;
		logic [19:0] page_count;
		logic [31:0] block_id;
		logic [31:0] offset_bytes;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] new_block_id;
		logic [31:0] data_offset;
	} rsp_t;

endpackage
`default_nettype wire

// ----- rtl/core/ffba_ram.sv -----
// Single-port-write, single-port-read table memory with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ffba_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- rtl/core/first_fit_block_allocator.sv -----
// Top level of the first-fit block allocator: sequencer plus free and allocation tables.
// Depends on ffba_pkg and ffba_ram.
//
//   channel   signals                      handshake
//   request   start, busy, req             taken when start & !busy, unless a pool write wins
//   result    done, rsp                    one-cycle strobe, no back-pressure
//   config    cfg_we, cfg_wdata            written when cfg_we in idle and cfg_wdata >= POOL_MIN
//
// A request rejected early gives its result word straight from S_EVAL. A reserve walks
// the free table one entry at a time, reading and then comparing each, and, when an entry
// empties, moves later entries down one by one; release and access walk the allocation
// table one entry at a time. Each table has one read port. After reset or a pool size
// write the block is busy in S_INIT, where it writes the first free-table entry.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_block_allocator #(
	parameter int PAGE_BYTES       = ffba_pkg::PAGE_BYTES_DEF,
	parameter int BLOCK_HDR_BYTES  = ffba_pkg::BLOCK_HDR_BYTES_DEF,
	parameter int DEVICE_HDR_BYTES = ffba_pkg::DEVICE_HDR_BYTES_DEF,
	parameter int MAX_FREE_BLOCKS  = ffba_pkg::MAX_FREE_BLOCKS_DEF,
	parameter int MAX_ALLOCATIONS  = ffba_pkg::MAX_ALLOCATIONS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire ffba_pkg::req_t req,
	output logic               done,
	output ffba_pkg::rsp_t     rsp,
	input  wire logic          cfg_we,
	input  wire logic [31:0]   cfg_wdata
);
	import ffba_pkg::*;

	localparam int FIDX_W = $clog2(MAX_FREE_BLOCKS);
	localparam int FCNT_W = $clog2(MAX_FREE_BLOCKS + 1);
	localparam int AIDX_W = $clog2(MAX_ALLOCATIONS);
	localparam int ACNT_W = $clog2(MAX_ALLOCATIONS + 1);
	localparam int PB_W   = $clog2(PAGE_BYTES + 1);
	localparam int LEN_W  = 20 + PB_W;
	localparam int NEED_W = LEN_W + 1;
	localparam int XW     = NEED_W + 1;
	localparam logic [31:0] DEV_HDR  = 32'(DEVICE_HDR_BYTES);
	localparam logic [31:0] BLK_HDR  = 32'(BLOCK_HDR_BYTES);
	localparam logic [31:0] POOL_MIN = POOL_MIN_RAW + DEV_HDR;
	localparam logic [31:0] USABLE_RESET = POOL_RESET - DEV_HDR - BLK_HDR;
	localparam logic [FCNT_W-1:0] FREE_MAX = FCNT_W'(MAX_FREE_BLOCKS);
	localparam logic [ACNT_W-1:0] ALLOC_MAX = ACNT_W'(MAX_ALLOCATIONS);

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_EVAL, S_FSCAN_RD, S_FSCAN_CMP,
		S_SHIFT_RD, S_SHIFT_WR, S_LK_RD, S_LK_CMP
	} state_t;

	state_t                state_q;
	req_t                  req_q;
	rsp_t                  rsp_q;
	logic                  done_q;
	logic [LEN_W-1:0]      len_q;
	logic [31:0]           pool_q;
	logic [31:0]           bytes_free_q;
	logic [FCNT_W-1:0]     free_count_q;
	logic [FCNT_W-1:0]     fidx_q;
	logic [ACNT_W-1:0]     aidx_q;
	logic [AIDX_W-1:0]     slot_q;
	logic [MAX_ALLOCATIONS-1:0] valid_q;

	logic                  f_we;
	logic [FIDX_W-1:0]     f_waddr, f_raddr;
	logic [63:0]           f_wdata, f_rdata;
	logic                  a_we;
	logic [AIDX_W-1:0]     a_waddr, a_raddr;
	logic [63:0]           a_wdata, a_rdata;

	logic [NEED_W-1:0]     need;
	logic [NEED_W-1:0]     rest;
	logic [31:0]           f_start, f_size, a_id, a_size;
	logic [31:0]           carve_id;
	logic                  fit;
	logic                  id_hit;
	logic                  range_bad;
	logic [AIDX_W-1:0]     slot_c;
	logic                  slot_found;
	logic [FCNT_W-1:0]     fidx_next;

	assign f_start  = f_rdata[63:32];
	assign f_size   = f_rdata[31:0];
	assign a_id     = a_rdata[63:32];
	assign a_size   = a_rdata[31:0];
	assign need     = NEED_W'(len_q) + NEED_W'(BLK_HDR);
	assign fit      = NEED_W'(f_size) >= need;
	assign rest     = NEED_W'(f_size) - need;
	assign carve_id = f_start + BLK_HDR + rest[31:0];
	assign id_hit   = valid_q[aidx_q[AIDX_W-1:0]] && (a_id == req_q.block_id);
	assign range_bad = (XW'(a_size) < XW'(len_q)) || (XW'(req_q.offset_bytes) >= XW'(a_size))
		|| ((XW'(req_q.offset_bytes) + XW'(len_q)) > XW'(a_size));
	assign fidx_next = fidx_q + FCNT_W'(1);

	always_comb begin
		slot_c = '0;
		slot_found = 1'b0;
		for (int i = MAX_ALLOCATIONS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				slot_c = AIDX_W'(i);
				slot_found = 1'b1;
			end
		end
	end

	always_comb begin
		f_we    = 1'b0;
		f_waddr = fidx_q[FIDX_W-1:0];
		f_wdata = {f_start, rest[31:0]};
		f_raddr = fidx_q[FIDX_W-1:0];
		a_we    = 1'b0;
		a_waddr = slot_q;
		a_wdata = {carve_id, 32'(len_q)};
		a_raddr = aidx_q[AIDX_W-1:0];
		unique case (state_q)
			S_INIT: begin
				f_we    = 1'b1;
				f_waddr = '0;
				f_wdata = {DEV_HDR, pool_q - DEV_HDR - BLK_HDR};
			end
			S_FSCAN_CMP: begin
				f_we = fit && (rest != '0);
				a_we = fit;
			end
			S_SHIFT_RD: begin
				f_raddr = fidx_next[FIDX_W-1:0];
			end
			S_SHIFT_WR: begin
				f_we    = 1'b1;
				f_wdata = f_rdata;
			end
			S_LK_CMP: begin
				f_we    = id_hit && (req_q.kind == KIND_RELEASE) && (free_count_q < FREE_MAX);
				f_waddr = free_count_q[FIDX_W-1:0];
				f_wdata = {req_q.block_id, a_size};
			end
			default: begin
			end
		endcase
	end

	ffba_ram #(.DEPTH(MAX_FREE_BLOCKS), .WIDTH(64)) u_free_ram (
		.clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
		.raddr(f_raddr), .rdata(f_rdata)
	);

	ffba_ram #(.DEPTH(MAX_ALLOCATIONS), .WIDTH(64)) u_alloc_ram (
		.clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
		.raddr(a_raddr), .rdata(a_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			done_q       <= 1'b0;
			pool_q       <= POOL_RESET;
			bytes_free_q <= USABLE_RESET;
			free_count_q <= FCNT_W'(1);
			valid_q      <= '0;
			fidx_q       <= '0;
			aidx_q       <= '0;
			slot_q       <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_INIT: begin
					state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (cfg_we && cfg_wdata >= POOL_MIN) begin
						pool_q       <= cfg_wdata;
						bytes_free_q <= cfg_wdata - DEV_HDR - BLK_HDR;
						free_count_q <= FCNT_W'(1);
						valid_q      <= '0;
						state_q      <= S_INIT;
					end else if (start) begin
						req_q   <= req;
						len_q   <= LEN_W'(req.page_count) * LEN_W'(PAGE_BYTES);
						fidx_q  <= '0;
						aidx_q  <= '0;
						rsp_q   <= '{status: ST_OK, new_block_id: '0, data_offset: '0};
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					slot_q <= slot_c;
					if (req_q.kind == KIND_RESERVE) begin
						if (req_q.page_count == '0) begin
							rsp_q.status <= ST_INVAL;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else if (NEED_W'(bytes_free_q) < need || !slot_found) begin
							rsp_q.status <= ST_NOMEM;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_FSCAN_RD;
						end
					end else if (req_q.block_id == '0
						|| (req_q.kind == KIND_RELEASE && req_q.page_count == '0)) begin
						rsp_q.status <= ST_INVAL;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_LK_RD;
					end
				end
				S_FSCAN_RD: begin
					if (fidx_q >= free_count_q) begin
						rsp_q.status <= ST_NOMEM;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_FSCAN_CMP;
					end
				end
				S_FSCAN_CMP: begin
					if (fit) begin
						bytes_free_q <= bytes_free_q - need[31:0];
						valid_q[slot_q] <= 1'b1;
						rsp_q.new_block_id <= carve_id;
						if (rest == '0) begin
							state_q <= S_SHIFT_RD;
						end else begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					end else begin
						fidx_q  <= fidx_next;
						state_q <= S_FSCAN_RD;
					end
				end
				S_SHIFT_RD: begin
					if (fidx_next < free_count_q) begin
						state_q <= S_SHIFT_WR;
					end else begin
						free_count_q <= free_count_q - FCNT_W'(1);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_SHIFT_WR: begin
					fidx_q  <= fidx_next;
					state_q <= S_SHIFT_RD;
				end
				S_LK_RD: begin
					if (aidx_q == ALLOC_MAX) begin
						rsp_q.status <= ST_INVAL;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_LK_CMP;
					end
				end
				S_LK_CMP: begin
					if (!id_hit) begin
						aidx_q  <= aidx_q + ACNT_W'(1);
						state_q <= S_LK_RD;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
						if (req_q.kind == KIND_RELEASE) begin
							if (free_count_q >= FREE_MAX) begin
								rsp_q.status <= ST_NOMEM;
							end else begin
								free_count_q <= free_count_q + FCNT_W'(1);
								bytes_free_q <= bytes_free_q + a_size;
								valid_q[aidx_q[AIDX_W-1:0]] <= 1'b0;
							end
						end else if (req_q.page_count != '0) begin
							if (range_bad) begin
								rsp_q.status <= ST_INVAL;
							end else begin
								rsp_q.data_offset <= req_q.block_id + BLK_HDR
									+ req_q.offset_bytes;
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;
endmodule
`default_nettype wire

// ----- rtl/core/ffba_checker.sv -----
// Port-level checks of the first-fit block allocator, bound to the top level.
// Depends on ffba_pkg and first_fit_block_allocator_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "first_fit_block_allocator_defines.svh"
module ffba_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           start,
	input wire logic           busy,
	input wire logic           done,
	input wire ffba_pkg::rsp_t rsp
);
	import ffba_pkg::*;

	`FFBA_AST_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`FFBA_AST_IMPLY(a_done_after_busy, clk, arst_n, done, $past(busy))
	`FFBA_AST_IMPLY(a_status_code, clk, arst_n, done, rsp.status <= ST_NOMEM)
	`FFBA_AST_IMPLY(a_fail_zero, clk, arst_n, done && rsp.status != ST_OK, rsp.new_block_id == '0 && rsp.data_offset == '0)
endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done), .rsp(rsp)
);
`default_nettype wire

// ----- tb/first_fit_block_allocator_tb.sv -----
// Self-checking testbench of the first-fit block allocator: directed, pool and random phases.
// Depends on ffba_pkg and first_fit_block_allocator; predicts every result word locally.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_block_allocator_tb;
	import ffba_pkg::*;

	localparam int PG = PAGE_BYTES_DEF;
	localparam int BH = BLOCK_HDR_BYTES_DEF;
	localparam int DH = DEVICE_HDR_BYTES_DEF;
	localparam int NF = MAX_FREE_BLOCKS_DEF;
	localparam int NA = MAX_ALLOCATIONS_DEF;
	localparam int WATCHDOG = 20000;
	localparam int N_RANDOM = 600;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;
	logic cfg_we;
	logic [31:0] cfg_wdata;

	first_fit_block_allocator u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// predicted allocator state
	logic [31:0] pool_sz;
	logic [31:0] fl_start [NF];
	logic [31:0] fl_size [NF];
	int fl_cnt;
	logic [31:0] al_id [NA];
	logic [31:0] al_size [NA];
	logic al_used [NA];
	logic [31:0] avail;

	rsp_t expected_q[$];
	int n_err, n_acc, n_rsp, n_ok, n_inval, n_nomem, idle_cnt;
	bit in_idle;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void pool_clear();
		logic [31:0] u;
		u = pool_sz - DH - BH;
		for (int i = 0; i < NF; i++) begin
			fl_start[i] = '0;
			fl_size[i] = '0;
		end
		for (int i = 0; i < NA; i++) begin
			al_id[i] = '0;
			al_size[i] = '0;
			al_used[i] = 1'b0;
		end
		fl_start[0] = DH;
		fl_size[0] = u;
		fl_cnt = 1;
		avail = u;
	endfunction

	function automatic int lookup_alloc(logic [31:0] id);
		for (int i = 0; i < NA; i++)
			if (al_used[i] && al_id[i] == id)
				return i;
		return -1;
	endfunction

	function automatic rsp_t allocate_result(req_t r);
		rsp_t o;
		logic [63:0] len, need, rest;
		int slot, i, k;
		o = '{status: ST_OK, new_block_id: '0, data_offset: '0};
		len = 64'(r.page_count) * PG;
		case (r.kind)
			KIND_RESERVE: begin
				need = len + BH;
				slot = -1;
				for (i = 0; i < NA; i++)
					if (!al_used[i] && slot < 0)
						slot = i;
				for (i = 0; i < fl_cnt; i++)
					if (64'(fl_size[i]) >= need)
						break;
				if (r.page_count == 0)
					o.status = ST_INVAL;
				else if (64'(avail) < need || slot < 0 || i >= fl_cnt)
					o.status = ST_NOMEM;
				else begin
					rest = 64'(fl_size[i]) - need;
					o.new_block_id = 32'(64'(fl_start[i]) + BH + rest);
					fl_size[i] = 32'(rest);
					avail = 32'(64'(avail) - need);
					if (rest == 0) begin
						for (int j = i; j + 1 < fl_cnt; j++) begin
							fl_start[j] = fl_start[j + 1];
							fl_size[j] = fl_size[j + 1];
						end
						fl_cnt--;
					end
					al_id[slot] = o.new_block_id;
					al_size[slot] = 32'(len);
					al_used[slot] = 1'b1;
				end
			end
			KIND_RELEASE: begin
				k = lookup_alloc(r.block_id);
				if (r.page_count == 0 || r.block_id == 0 || k < 0)
					o.status = ST_INVAL;
				else if (fl_cnt >= NF)
					o.status = ST_NOMEM;
				else begin
					fl_start[fl_cnt] = r.block_id;
					fl_size[fl_cnt] = al_size[k];
					fl_cnt++;
					avail = avail + al_size[k];
					al_used[k] = 1'b0;
				end
			end
			default: begin
				k = lookup_alloc(r.block_id);
				if (r.block_id == 0 || k < 0)
					o.status = ST_INVAL;
				else if (r.page_count != 0) begin
					if (64'(al_size[k]) < len || 64'(r.offset_bytes) >= 64'(al_size[k])
							|| 64'(r.offset_bytes) + len > 64'(al_size[k]))
						o.status = ST_INVAL;
					else
						o.data_offset = r.block_id + BH + r.offset_bytes;
				end
			end
		endcase
		return o;
	endfunction

	// result checker
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && done) begin
			n_rsp++;
			if (expected_q.size() == 0) begin
				n_err++;
				if (n_err <= 10)
					$display("unexpected result word: %p", rsp);
			end else begin
				e = expected_q.pop_front();
				case (e.status)
					ST_OK: n_ok++;
					ST_INVAL: n_inval++;
					default: n_nomem++;
				endcase
				if (rsp.status !== e.status || rsp.new_block_id !== e.new_block_id
						|| rsp.data_offset !== e.data_offset) begin
					n_err++;
					if (n_err <= 10)
						$display("mismatch: expected %p actual %p", e, rsp);
				end
			end
		end
	end

	// watchdog on stalled progress
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt > WATCHDOG) begin
			$display("watchdog expired");
			$display("first_fit_block_allocator_tb: errors");
			$finish;
		end
	end

	// send one word; an optional typed-in result overrides the predicted one
	task automatic send_word(req_t r, bit have_exp, rsp_t ex);
		rsp_t p;
		int gap;
		if (in_idle && $urandom_range(3) == 0) begin
			gap = $urandom_range(9, 1);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		p = allocate_result(r);
		if (have_exp && p != ex) begin
			n_err++;
			if (n_err <= 10)
				$display("table row disagrees with prediction: %p vs %p", ex, p);
		end
		expected_q.push_back(have_exp ? ex : p);
		n_acc++;
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_pool(logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (64'(v) >= 64'(DH) + 64'(POOL_MIN_RAW)) begin
			pool_sz = v;
			pool_clear();
		end
		repeat (3) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_id();
		int c;
		c = $urandom_range(9);
		if (c == 0)
			return $urandom;
		if (c == 1)
			return 32'd0;
		for (int t = 0; t < 8; t++) begin
			int i;
			i = $urandom_range(NA - 1);
			if (al_used[i])
				return al_id[i];
		end
		return $urandom;
	endfunction

	function automatic req_t rand_word();
		req_t r;
		int c, k;
		r.kind = kind_t'($urandom_range(3));
		r.block_id = $urandom;
		r.offset_bytes = $urandom;
		c = $urandom_range(19);
		if (c == 0)
			r.page_count = 20'($urandom);
		else if (c == 1)
			r.page_count = '0;
		else
			r.page_count = 20'($urandom_range(c < 5 ? 300 : 8, 1));
		if (r.kind != KIND_RESERVE) begin
			r.block_id = pick_id();
			k = lookup_alloc(r.block_id);
			if (r.kind != KIND_RELEASE && k >= 0 && $urandom_range(3) != 0) begin
				int pg;
				pg = al_size[k] / PG;
				r.page_count = 20'($urandom_range(pg));
				r.offset_bytes = $urandom_range(al_size[k] - r.page_count * PG);
			end
		end
		return r;
	endfunction

	typedef struct {
		req_t r;
		bit have_exp;
		rsp_t ex;
	} row_t;

	row_t dir_tab[$];

	function automatic row_t mk(kind_t k, logic [19:0] pg, logic [31:0] id, logic [31:0] off,
			bit h, status_t s, logic [31:0] nid, logic [31:0] dof);
		row_t w;
		w.r = '{kind: k, page_count: pg, block_id: id, offset_bytes: off};
		w.have_exp = h;
		w.ex = '{status: s, new_block_id: nid, data_offset: dof};
		return w;
	endfunction

	localparam logic [31:0] ID0 = 32'd4194304 - BH - PG;

	initial begin
		req_t r;
		n_err = 0; n_acc = 0; n_rsp = 0; n_ok = 0; n_inval = 0; n_nomem = 0;
		idle_cnt = 0;
		in_idle = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		pool_sz = POOL_RESET;
		pool_clear();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		dir_tab.push_back(mk(KIND_RESERVE, 20'd0, 32'd0, 32'd0, 1, ST_INVAL, 0, 0));
		dir_tab.push_back(mk(KIND_RESERVE, 20'hFFFFF, '1, '1, 1, ST_NOMEM, 0, 0));
		dir_tab.push_back(mk(KIND_RESERVE, 20'd1, '1, '1, 1, ST_OK, ID0, 0));
		dir_tab.push_back(mk(KIND_READ, 20'd1, ID0, 32'd0, 1, ST_OK, 0, ID0 + BH));
		dir_tab.push_back(mk(KIND_WRITE, 20'd0, ID0, '1, 1, ST_OK, 0, 0));
		dir_tab.push_back(mk(KIND_WRITE, 20'd2, ID0, 32'd0, 1, ST_INVAL, 0, 0));
		dir_tab.push_back(mk(KIND_READ, 20'd1, ID0, 32'd1, 1, ST_INVAL, 0, 0));
		dir_tab.push_back(mk(KIND_READ, 20'd1, ID0, '1, 1, ST_INVAL, 0, 0));
		dir_tab.push_back(mk(KIND_READ, 20'd1, 32'd0, 32'd0, 1, ST_INVAL, 0, 0));
		dir_tab.push_back(mk(KIND_WRITE, 20'd1, 32'h1234, 32'd0, 1, ST_INVAL, 0, 0));
		dir_tab.push_back(mk(KIND_RELEASE, 20'd0, ID0, 32'd0, 1, ST_INVAL, 0, 0));
		dir_tab.push_back(mk(KIND_RELEASE, 20'd1, 32'd0, 32'd0, 1, ST_INVAL, 0, 0));
		dir_tab.push_back(mk(KIND_RELEASE, 20'hFFFFF, ID0, '1, 1, ST_OK, 0, 0));
		dir_tab.push_back(mk(KIND_RELEASE, 20'd1, ID0, 32'd0, 1, ST_INVAL, 0, 0));
		for (int i = 0; i < NA + 1; i++)
			dir_tab.push_back(mk(KIND_RESERVE, 20'd1, 0, 0, 0, ST_OK, 0, 0));
		foreach (dir_tab[i])
			send_word(dir_tab[i].r, dir_tab[i].have_exp, dir_tab[i].ex);
		drain();

		// free-table overflow: release every allocation that the directed table filled
		for (int i = 0; i < NA; i++) begin
			r = '{kind: KIND_RELEASE, page_count: 20'd1, block_id: al_id[i], offset_bytes: '0};
			send_word(r, 0, '0);
		end
		drain();

		write_pool(32'd1000);
		write_pool(32'(DH) + POOL_MIN_RAW - 1);
		write_pool(32'(DH) + POOL_MIN_RAW);
		in_idle = 1'b1;
		for (int ph = 0; ph < 4; ph++) begin
			if (ph == 1)
				write_pool('1);
			else if (ph == 2)
				write_pool(32'(DH) + POOL_MIN_RAW + $urandom_range(1 << 22));
			else if (ph == 3) begin
				write_pool(POOL_RESET);
				in_idle = 1'b0;
			end
			for (int n = 0; n < N_RANDOM / 4; n++)
				send_word(rand_word(), 0, '0);
			drain();
		end

		$display("covered %0d requests, %0d results: %0d ok, %0d invalid, %0d no-memory",
			n_acc, n_rsp, n_ok, n_inval, n_nomem);
		$display("pool sizes from minimum to full 32-bit range, %0d mismatches", n_err);
		if (n_err == 0 && expected_q.size() == 0)
			$display("first_fit_block_allocator_tb: clean");
		else
			$display("first_fit_block_allocator_tb: errors");
		$finish;
	end
endmodule
`default_nettype wire

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/ffba_pkg.sv
rtl/core/ffba_ram.sv
rtl/core/first_fit_block_allocator.sv
rtl/core/ffba_checker.sv
tb/first_fit_block_allocator_tb.sv
